### hdl/swsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swsm_pkg;

  // Stack geometry.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths fixed by the interface.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned SUM_W   = 36;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_PUSH_FULL  = 2'd1;
  localparam logic [1:0] STATUS_POP_EMPTY  = 2'd2;

  // One request.
  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  // One result.
  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [SUM_W-1:0]  entry_sum;
    logic signed [DATA_W-1:0] entry_max;
  } res_t;

endpackage : swsm_pkg

`default_nettype wire

### hdl/swsm_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module swsm_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire swsm_pkg::req_t req_i,
  input  wire logic          drain_i,
  output logic               fire_o,
  output swsm_pkg::req_t     req_o
);

  logic           valid_q;
  logic           valid_d;
  logic           load;
  swsm_pkg::req_t req_q;

  // The held request moves on whenever the result side can take it.
  assign fire_o  = valid_q & drain_i;
  assign stall_o = valid_q & ~drain_i;
  assign load    = valid_i & ~stall_o;
  assign valid_d = load | (valid_q & ~drain_i);
  assign req_o   = req_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture on each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

endmodule : swsm_in_reg

`default_nettype wire

### hdl/swsm_stack.sv
`timescale 1ns / 1ps
`default_nettype none

module swsm_stack (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           exec_i,
  input  wire swsm_pkg::req_t req_i,
  output swsm_pkg::res_t      res_o
);

  localparam int unsigned CW = swsm_pkg::CNT_W;
  localparam int unsigned AW = swsm_pkg::ADDR_W;
  localparam int unsigned DW = swsm_pkg::DATA_W;
  localparam int unsigned SW = swsm_pkg::SUM_W;

  logic [DW-1:0] entry_mem [swsm_pkg::DEPTH];
  logic [DW-1:0] max_mem   [swsm_pkg::DEPTH];

  logic [CW-1:0]        fill_q;
  logic [CW-1:0]        fill_d;
  logic signed [SW-1:0] sum_q;
  logic signed [SW-1:0] sum_d;
  logic signed [DW-1:0] max_q;
  logic signed [DW-1:0] max_d;
  logic signed [DW-1:0] top_q;
  logic signed [DW-1:0] below_max_q;

  logic                 full;
  logic                 empty;
  logic [AW-1:0]        wr_idx;
  logic [AW-1:0]        below_idx;
  logic [AW-1:0]        under_idx;
  logic signed [DW-1:0] new_max;
  logic signed [DW-1:0] popped;
  logic [1:0]           status;
  logic                 do_push;
  logic                 do_pop;

  // Pointers into the stores. A pop reloads the top entry from the slot below it
  // and the maximum under that from two slots below; reads past the bottom are
  // never used.
  assign full      = (fill_q == CW'(swsm_pkg::DEPTH));
  assign empty     = (fill_q == '0);
  assign wr_idx    = AW'(fill_q);
  assign below_idx = AW'(fill_q - CW'(2));
  assign under_idx = AW'(fill_q - CW'(3));

  // The running maximum of a new entry folds in the current maximum.
  assign new_max = (!empty && (max_q > req_i.push_value)) ? max_q : req_i.push_value;

  // Next state and result for the request at hand.
  always_comb begin
    fill_d  = fill_q;
    sum_d   = sum_q;
    max_d   = max_q;
    popped  = '0;
    status  = swsm_pkg::STATUS_OK;
    do_push = 1'b0;
    do_pop  = 1'b0;
    case (req_i.req_type)
      swsm_pkg::REQ_PUSH: begin
        if (full) begin
          status = swsm_pkg::STATUS_PUSH_FULL;
        end else begin
          do_push = 1'b1;
          fill_d  = fill_q + CW'(1);
          sum_d   = sum_q + SW'(req_i.push_value);
          max_d   = new_max;
        end
      end
      swsm_pkg::REQ_POP: begin
        if (empty) begin
          status = swsm_pkg::STATUS_POP_EMPTY;
        end else begin
          do_pop = 1'b1;
          popped = top_q;
          fill_d = fill_q - CW'(1);
          sum_d  = sum_q - SW'(top_q);
          max_d  = (fill_q > CW'(1)) ? below_max_q : '0;
        end
      end
      default: begin
        status = swsm_pkg::STATUS_OK;
      end
    endcase
  end

  // Result of the request, taken by the result register.
  always_comb begin
    res_o.popped_value = popped;
    res_o.status       = status;
    res_o.entry_count  = swsm_pkg::COUNT_W'(fill_d);
    res_o.entry_sum    = (fill_d != '0) ? sum_d : '0;
    res_o.entry_max    = max_d;
  end

  // Fill level, running sum and current maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      max_q  <= '0;
    end else if (exec_i) begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
      max_q  <= max_d;
    end
  end

  // Entry and running-maximum stores, written at the slot above the top. The top
  // entry and the maximum just below it are held in registers next to the stores.
  always_ff @(posedge clk_i) begin
    if (exec_i && do_push) begin
      entry_mem[wr_idx] <= req_i.push_value;
      max_mem[wr_idx]   <= new_max;
      top_q             <= req_i.push_value;
      below_max_q       <= max_q;
    end else if (exec_i && do_pop) begin
      top_q       <= entry_mem[below_idx];
      below_max_q <= max_mem[under_idx];
    end
  end

  // The fill level never passes the depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(swsm_pkg::DEPTH))
    else $error("fill level beyond depth");

  // An empty stack carries a zero sum and a zero maximum.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> (sum_q == '0) && (max_q == '0))
    else $error("empty stack with nonzero sum or maximum");

  // A refused request leaves the stack as it was.
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && (status != swsm_pkg::STATUS_OK)
    |=> $stable(fill_q) && $stable(sum_q) && $stable(max_q))
    else $error("refused request changed the stack");

  // A successful pop lowers the fill level by one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && do_pop |=> fill_q == $past(fill_q) - CW'(1))
    else $error("pop did not lower the fill level");

endmodule : swsm_stack

`default_nettype wire

### hdl/swsm_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module swsm_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire swsm_pkg::res_t res_i,
  output logic                ready_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output swsm_pkg::res_t      res_o
);

  logic           valid_q;
  logic           valid_d;
  swsm_pkg::res_t res_q;

  // A new result may enter when the register is empty or being drained.
  assign ready_o = ~valid_q | ~stall_i;
  assign valid_d = load_i | (valid_q & stall_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule : swsm_out_reg

`default_nettype wire

### hdl/stack_with_sum_and_max_core.sv
// LIFO stack of 16 signed 32-bit entries that reports, for every push or pop
// transaction, the popped value, a status, the entry count, and the exact sum
// and maximum of the held entries after the operation (both 0 when empty).
// A push onto a full stack or a pop from an empty one is refused with an
// error status and leaves the stack unchanged. The block takes one
// transaction per clock cycle while the output is not stalled; a request is
// held in the request register and its result in the result register. The
// fill pointer, the running sum and the current maximum are updated once for
// every request, which reads and writes them. The stored entries have no
// reset; only held entries are ever used.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_sum_and_max_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic signed [31:0] push_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      popped_value_o,
  output logic [1:0]              status_o,
  output logic [4:0]              entry_count_o,
  output logic signed [35:0]      entry_sum_o,
  output logic signed [31:0]      entry_max_o
);

  swsm_pkg::req_t in_req;
  swsm_pkg::req_t held_req;
  swsm_pkg::res_t exec_res;
  swsm_pkg::res_t out_res;
  logic           exec_fire;
  logic           out_ready;

  assign in_req.req_type   = req_type_i;
  assign in_req.push_value = push_value_i;

  // Request register.
  swsm_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .req_i   (in_req),
    .drain_i (out_ready),
    .fire_o  (exec_fire),
    .req_o   (held_req)
  );

  // Stack state and the per-request update.
  swsm_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec_fire),
    .req_i  (held_req),
    .res_o  (exec_res)
  );

  // Result register.
  swsm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (exec_fire),
    .res_i   (exec_res),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign popped_value_o = out_res.popped_value;
  assign status_o       = out_res.status;
  assign entry_count_o  = out_res.entry_count;
  assign entry_sum_o    = out_res.entry_sum;
  assign entry_max_o    = out_res.entry_max;

endmodule : stack_with_sum_and_max_core

`default_nettype wire
